### hdl/altr_pkg.sv
// ----------------------------------------------------------------------------
// altr_pkg
// Shared widths, stream layout, action codes and the search token that walks
// the sample chain of the arc-length reparameterization block.
// ----------------------------------------------------------------------------
package altr_pkg;

  // Field widths
  localparam int ACT_W  = 2;
  localparam int IDX_W  = 6;
  localparam int PROG_W = 17;
  localparam int DIST_W = 24;
  localparam int ID_W   = 32;

  // Interpolation products and the dividend built from them
  localparam int PROD_W = DIST_W + PROG_W;
  localparam int NUM_W  = PROD_W + 1;

  // Input beat layout, lowest bit first
  localparam int OFS_ACT   = 0;
  localparam int OFS_IDX   = OFS_ACT + ACT_W;
  localparam int OFS_EPROG = OFS_IDX + IDX_W;
  localparam int OFS_EDIST = OFS_EPROG + PROG_W;
  localparam int OFS_SYNC  = OFS_EDIST + DIST_W;
  localparam int OFS_QPROG = OFS_SYNC + ID_W;
  localparam int IN_BITS   = OFS_QPROG + PROG_W;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((PROG_W + 7) / 8) * 8;

  // 1.0 in unsigned Q1.16
  localparam logic [PROG_W-1:0] Q16_ONE = 17'h10000;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SET_ID = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  // Search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              at_head;  // set only on the way into the first cell
    logic              found;
    logic              first;    // hit was on the first sample
    logic [DIST_W-1:0] target;
    logic [DIST_W-1:0] prev_d;   // distance of the cell just left
    logic [PROG_W-1:0] prev_p;   // parameter of the cell just left
    logic [DIST_W-1:0] d_lo;
    logic [PROG_W-1:0] p_lo;
    logic [DIST_W-1:0] d_hi;
    logic [PROG_W-1:0] p_hi;
  } token_t;

  // Saturate a Q1.16 value at 1.0
  function automatic logic [PROG_W-1:0] clamp_one(input logic [PROG_W-1:0] v);
    return (v > Q16_ONE) ? Q16_ONE : v;
  endfunction

endpackage

### hdl/altr_cell.sv
// ----------------------------------------------------------------------------
// altr_cell
// One table sample (parameter and cumulative distance) plus one stage of the
// search chain: the first cell whose distance reaches the target latches the
// bracketing pair into the token.
// ----------------------------------------------------------------------------
module altr_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [altr_pkg::PROG_W-1:0] wr_prog_i,
  input  logic [altr_pkg::DIST_W-1:0] wr_dist_i,
  input  altr_pkg::token_t            tok_i,
  output altr_pkg::token_t            tok_o
);
  import altr_pkg::*;

  logic [PROG_W-1:0] prog_q;
  logic [DIST_W-1:0] dist_q;
  token_t            tok_q, tok_d;

  // Sample storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q <= '0;
      dist_q <= '0;
    end else if (wr_en_i) begin
      prog_q <= wr_prog_i;
      dist_q <= wr_dist_i;
    end
  end

  // Compare against the passing token
  always_comb begin
    tok_d         = tok_i;
    tok_d.at_head = 1'b0;
    tok_d.prev_d  = dist_q;
    tok_d.prev_p  = prog_q;
    if (tok_i.valid && !tok_i.found && (dist_q >= tok_i.target)) begin
      tok_d.found = 1'b1;
      tok_d.first = tok_i.at_head;
      tok_d.d_lo  = tok_i.prev_d;
      tok_d.p_lo  = tok_i.prev_p;
      tok_d.d_hi  = dist_q;
      tok_d.p_hi  = prog_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### hdl/altr_div.sv
// ----------------------------------------------------------------------------
// altr_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in PROG_W bits, so the upper dividend bits seed the
// partial remainder directly.
// ----------------------------------------------------------------------------
module altr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [altr_pkg::NUM_W-1:0]  num_i,
  input  logic [altr_pkg::DIST_W-1:0] den_i,
  output logic                        done_o,
  output logic [altr_pkg::PROG_W-1:0] quot_o
);
  import altr_pkg::*;

  localparam int CNT_W = $clog2(PROG_W);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIST_W-1:0] rem_q, den_q;
  logic [PROG_W-1:0] qsh_q;
  logic [DIST_W:0]   trial;
  logic              ge;

  // One restoring step
  assign trial = {rem_q, qsh_q[PROG_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(PROG_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PROG_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[NUM_W-2:PROG_W];
      qsh_q <= num_i[PROG_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? DIST_W'(trial - {1'b0, den_q}) : trial[DIST_W-1:0];
      qsh_q <= {qsh_q[PROG_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = qsh_q;

endmodule

### hdl/arc_length_table_reparameterize.sv
// ----------------------------------------------------------------------------
// arc_length_table_reparameterize
// Arc-length lookup table: loads samples and a table id, answers queries with
// a linearly interpolated curve parameter.
// ----------------------------------------------------------------------------
// Samples live in a row of SAMPLE_COUNT+1 cells; a query launches a token that
// walks the row one cell per cycle and picks up the first sample reaching the
// target distance. Sample writes and id writes give no result. A query that
// falls through at the ends of the move, on an id mismatch or on a tiny target
// returns without the search and the divider; a full query goes through the
// target multiply, the walk down the cell row (the last step of which also
// forms the interpolation products), the sum, the bit-serial divider, and the
// load of the output register. One item is worked on at a time; the next beat
// is taken as soon as the result sits in the output register.
// ----------------------------------------------------------------------------
module arc_length_table_reparameterize #(
  parameter int SAMPLE_COUNT = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // action, entry_index, entry_progress, entry_distance, sync_id, query_progress
  input  logic [altr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // curve_param
  output logic [altr_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import altr_pkg::*;

  localparam int CELLS = SAMPLE_COUNT + 1;
  localparam int TGT_W = DIST_W + PROG_W - 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TARGET,
    ST_LAUNCH,
    ST_SEARCH,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e            state_q;
  logic [ID_W-1:0]   table_id_q;
  logic [PROG_W-1:0] p_q, res_q;
  logic [DIST_W-1:0] target_q, den_q;
  logic [PROD_W-1:0] prod_a_q, prod_b_q;
  logic              m_valid_q;
  logic [PROG_W-1:0] m_data_q;

  // Beat fields
  logic [ACT_W-1:0]  in_action;
  logic [IDX_W-1:0]  in_index;
  logic [PROG_W-1:0] in_eprog, in_qprog, q_prog;
  logic [DIST_W-1:0] in_edist;
  logic [ID_W-1:0]   in_sync;
  logic              accept, wr_sample, bypass, out_free;

  assign in_action = s_axis_tdata[OFS_ACT   +: ACT_W];
  assign in_index  = s_axis_tdata[OFS_IDX   +: IDX_W];
  assign in_eprog  = s_axis_tdata[OFS_EPROG +: PROG_W];
  assign in_edist  = s_axis_tdata[OFS_EDIST +: DIST_W];
  assign in_sync   = s_axis_tdata[OFS_SYNC  +: ID_W];
  assign in_qprog  = s_axis_tdata[OFS_QPROG +: PROG_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wr_sample     = accept && (in_action == ACT_WRITE);
  assign q_prog        = clamp_one(in_qprog);
  assign bypass        = (q_prog == '0) || (q_prog >= Q16_ONE) || (in_sync != table_id_q);
  assign out_free      = !m_valid_q || m_axis_tready;

  // Cell row
  token_t                chain [CELLS+1];
  logic [PROG_W-1:0]     wr_prog;
  logic [DIST_W-1:0]     total;
  logic [TGT_W-1:0]      tgt_prod;
  token_t                tok_end;

  assign wr_prog = clamp_one(in_eprog);

  always_comb begin
    chain[0]         = '0;
    chain[0].valid   = (state_q == ST_LAUNCH) && (target_q > DIST_W'(1));
    chain[0].at_head = 1'b1;
    chain[0].target  = target_q;
  end

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    altr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_sample && (int'(in_index) == k)),
      .wr_prog_i (wr_prog),
      .wr_dist_i (in_edist),
      .tok_i     (chain[k]),
      .tok_o     (chain[k+1])
    );
  end

  // The last cell always reports its own distance: the path total
  assign tok_end  = chain[CELLS];
  assign total    = tok_end.prev_d;
  assign tgt_prod = TGT_W'(total) * TGT_W'(p_q[PROG_W-2:0]);

  // Divider
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num;
  logic [PROG_W-1:0] div_quot;

  assign div_start = (state_q == ST_SUM);
  assign div_num   = NUM_W'(prod_a_q) + NUM_W'(prod_b_q);

  altr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      table_id_q <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      p_q        <= '0;
      res_q      <= '0;
      target_q   <= '0;
      den_q      <= '0;
      prod_a_q   <= '0;
      prod_b_q   <= '0;
    end else begin
      // ST_OUT reloads the register itself
      if (m_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (in_action)
              ACT_SET_ID: table_id_q <= in_sync;
              ACT_QUERY: begin
                p_q   <= q_prog;
                res_q <= q_prog;
                state_q <= bypass ? ST_OUT : ST_TARGET;
              end
              default: ;
            endcase
          end
        end
        ST_TARGET: begin
          target_q <= tgt_prod[TGT_W-1:PROG_W-1];
          state_q  <= ST_LAUNCH;
        end
        ST_LAUNCH: begin
          state_q <= (target_q > DIST_W'(1)) ? ST_SEARCH : ST_OUT;
        end
        ST_SEARCH: begin
          if (tok_end.valid) begin
            if (!tok_end.found) begin
              res_q   <= '0;
              state_q <= ST_OUT;
            end else if (tok_end.first) begin
              res_q   <= tok_end.p_hi;
              state_q <= ST_OUT;
            end else begin
              prod_a_q <= PROD_W'(tok_end.d_hi - target_q) * PROD_W'(tok_end.p_lo);
              prod_b_q <= PROD_W'(target_q - tok_end.d_lo) * PROD_W'(tok_end.p_hi);
              den_q    <= tok_end.d_hi - tok_end.d_lo;
              state_q  <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            res_q   <= div_quot;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= res_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(m_data_q);

endmodule

### hdl/altr_checker.sv
// ----------------------------------------------------------------------------
// altr_checker
// Port-level checks for the arc-length table: output beat handling, result
// range, and that results only follow accepted queries.
// ----------------------------------------------------------------------------
module altr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [altr_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [altr_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import altr_pkg::*;

  logic       q_beat, r_beat;
  logic [2:0] pending_q;

  assign q_beat = s_axis_tvalid && s_axis_tready &&
                  (s_axis_tdata[OFS_ACT +: ACT_W] == ACT_QUERY);
  assign r_beat = m_axis_tvalid && m_axis_tready;

  // Queries accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {2'b0, q_beat} - {2'b0, r_beat};
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_param_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata <= M_TDATA_W'(Q16_ONE)))
    else $error("curve parameter above 1.0 or padding not zero");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd2)
    else $error("more than two queries outstanding");

  a_result_has_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pending_q != 3'd0))
    else $error("result beat without an accepted query");

endmodule

bind arc_length_table_reparameterize altr_checker u_altr_checker (.*);
